// ----- src/lhc_pkg.sv -----
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared types and constants of the leftist heap collection.
// ----------------------------------------------------------------------------
package lhc_pkg;

   localparam int KEY_W  = 32;
   localparam int RANK_W = 4;
   localparam int CMD_W  = 2;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
   localparam logic [RANK_W-1:0] RANK_ONE = 4'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_MELD   = 2'd1,
      CMD_DELMIN = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_WALK,
      ST_WALK_A,
      ST_WALK_B,
      ST_TAIL,
      ST_POP,
      ST_POP_X,
      ST_POP_L,
      ST_POP_W,
      ST_FIN_WR,
      ST_DEL_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic done;
      logic status;
   } ctrl_stat_type;

endpackage

// ----- src/lhc_ram.sv -----
// ----------------------------------------------------------------------------
// lhc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/lhc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhc_ctrl
// Command sequencer: walks the right spines, unwinds them through the spine
// stack and rewrites node records in the node memory.
// ----------------------------------------------------------------------------
module lhc_ctrl #(
   parameter int MAX_ITEMS   = 1024,
   parameter int SPINE_DEPTH = 24,
   localparam int IDX_W = $clog2(MAX_ITEMS + 1),
   localparam int SP_W  = $clog2(SPINE_DEPTH),
   localparam int REC_W = lhc_pkg::KEY_W + 2 * IDX_W + lhc_pkg::RANK_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       idle,
   input  lhc_pkg::cmd_type           cmd,
   input  logic [IDX_W-1:0]           first_index,
   input  logic [IDX_W-1:0]           second_index,
   input  logic [lhc_pkg::KEY_W-1:0]  item_key,
   input  logic                       rsp_free,
   output lhc_pkg::ctrl_stat_type     stat,
   output logic [IDX_W-1:0]           result_root,
   output logic [IDX_W-1:0]           removed_item,
   output logic                       node_we,
   output logic [IDX_W-1:0]           node_waddr,
   output logic [REC_W-1:0]           node_wdata,
   output logic                       node_re,
   output logic [IDX_W-1:0]           node_raddr,
   input  logic [REC_W-1:0]           node_rdata,
   output logic                       stk_we,
   output logic [SP_W-1:0]            stk_addr_w,
   output logic [IDX_W-1:0]           stk_wdata,
   output logic                       stk_re,
   output logic [SP_W-1:0]            stk_addr_r,
   input  logic [IDX_W-1:0]           stk_rdata
);

   localparam int KW = lhc_pkg::KEY_W;
   localparam int RW = lhc_pkg::RANK_W;
   localparam int DEP_W = $clog2(SPINE_DEPTH + 1);
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ITEMS);
   localparam logic [DEP_W-1:0] DEP_MAX = DEP_W'(SPINE_DEPTH);

   lhc_pkg::state_type state_ff, state_in;
   lhc_pkg::cmd_type   cmd_ff, cmd_in;
   logic [IDX_W-1:0] f_ff, f_in, s_ff, s_in;
   logic [KW-1:0]    key_ff, key_in, ks_ff, ks_in, ka_ff, ka_in;
   logic [IDX_W-1:0] a_ff, a_in, b_ff, b_in, ra_ff, ra_in;
   logic [IDX_W-1:0] tail_ff, tail_in, x_ff, x_in, xl_ff, xl_in;
   logic [KW-1:0]    xk_ff, xk_in;
   logic [RW-1:0]    trank_ff, trank_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic             err_ff, err_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   logic [KW-1:0]    rd_key_raw, rd_key;
   logic [IDX_W-1:0] rd_left, rd_right;
   logic [RW-1:0]    rd_rank, new_rank, rank_src;
   logic             greater, spine_end, swap;

   assign {rd_key_raw, rd_left, rd_right, rd_rank} = node_rdata;
   assign rd_key = (cmd_ff == lhc_pkg::CMD_INSERT && rd_idx_ff == f_ff) ? key_ff : rd_key_raw;
   assign greater = $signed(ka_ff) > $signed(rd_key);
   assign spine_end = (a_ff == '0) || (b_ff == '0) || (a_ff == b_ff);
   assign swap = rd_rank < trank_ff;
   assign rank_src = swap ? rd_rank : trank_ff;
   assign new_rank = (rank_src == lhc_pkg::RANK_MAX) ? lhc_pkg::RANK_MAX : rank_src + RW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhc_pkg::ST_CLEAR: begin
            if (clr_ff == MAX_IDX) state_in = lhc_pkg::ST_IDLE;
         end
         lhc_pkg::ST_IDLE: begin
            if (start) state_in = lhc_pkg::ST_START;
         end
         lhc_pkg::ST_START: begin
            case (cmd_ff)
               lhc_pkg::CMD_INSERT: begin
                  state_in = (f_ff > MAX_IDX || s_ff > MAX_IDX) ?
                             lhc_pkg::ST_DONE : lhc_pkg::ST_CHECK;
               end
               lhc_pkg::CMD_MELD: begin
                  state_in = (f_ff > MAX_IDX || s_ff > MAX_IDX) ?
                             lhc_pkg::ST_DONE : lhc_pkg::ST_WALK;
               end
               lhc_pkg::CMD_DELMIN: begin
                  state_in = (s_ff > MAX_IDX || s_ff == '0) ?
                             lhc_pkg::ST_DONE : lhc_pkg::ST_CHECK;
               end
               default: state_in = lhc_pkg::ST_DONE;
            endcase
         end
         lhc_pkg::ST_CHECK: begin
            if (cmd_ff == lhc_pkg::CMD_INSERT &&
                (rd_left != '0 || rd_right != '0 || rd_rank != lhc_pkg::RANK_ONE)) begin
               state_in = lhc_pkg::ST_DONE;
            end else begin
               state_in = lhc_pkg::ST_WALK;
            end
         end
         lhc_pkg::ST_WALK: state_in = spine_end ? lhc_pkg::ST_TAIL : lhc_pkg::ST_WALK_A;
         lhc_pkg::ST_WALK_A: state_in = lhc_pkg::ST_WALK_B;
         lhc_pkg::ST_WALK_B: begin
            state_in = (depth_ff == DEP_MAX) ? lhc_pkg::ST_DONE : lhc_pkg::ST_WALK;
         end
         lhc_pkg::ST_TAIL: state_in = lhc_pkg::ST_POP;
         lhc_pkg::ST_POP: begin
            if (depth_ff != '0) begin
               state_in = lhc_pkg::ST_POP_X;
            end else begin
               case (cmd_ff)
                  lhc_pkg::CMD_INSERT: state_in = lhc_pkg::ST_FIN_WR;
                  lhc_pkg::CMD_DELMIN: state_in = lhc_pkg::ST_DEL_WR;
                  default:             state_in = lhc_pkg::ST_DONE;
               endcase
            end
         end
         lhc_pkg::ST_POP_X: state_in = lhc_pkg::ST_POP_L;
         lhc_pkg::ST_POP_L: state_in = lhc_pkg::ST_POP_W;
         lhc_pkg::ST_POP_W: state_in = lhc_pkg::ST_POP;
         lhc_pkg::ST_FIN_WR: state_in = lhc_pkg::ST_DONE;
         lhc_pkg::ST_DEL_WR: state_in = lhc_pkg::ST_DONE;
         lhc_pkg::ST_DONE: begin
            if (rsp_free) state_in = lhc_pkg::ST_IDLE;
         end
         default: state_in = lhc_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory ports and outputs.
   always_comb begin
      cmd_in = cmd_ff;
      f_in = f_ff;
      s_in = s_ff;
      key_in = key_ff;
      ks_in = ks_ff;
      ka_in = ka_ff;
      a_in = a_ff;
      b_in = b_ff;
      ra_in = ra_ff;
      tail_in = tail_ff;
      x_in = x_ff;
      xl_in = xl_ff;
      xk_in = xk_ff;
      trank_in = trank_ff;
      depth_in = depth_ff;
      err_in = err_ff;
      rd_idx_in = rd_idx_ff;
      clr_in = clr_ff;
      node_we = 1'b0;
      node_waddr = clr_ff;
      node_wdata = {KW'(0), IDX_W'(0), IDX_W'(0),
                    (clr_ff == '0) ? RW'(0) : lhc_pkg::RANK_ONE};
      node_re = 1'b0;
      node_raddr = a_ff;
      stk_we = 1'b0;
      stk_addr_w = depth_ff[SP_W-1:0];
      stk_wdata = a_ff;
      stk_re = 1'b0;
      stk_addr_r = SP_W'(depth_ff - DEP_W'(1));
      idle = 1'b0;
      stat.done = 1'b0;
      stat.status = err_ff;
      case (state_ff)
         lhc_pkg::ST_CLEAR: begin
            node_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
         end
         lhc_pkg::ST_IDLE: begin
            idle = 1'b1;
            cmd_in = cmd;
            f_in = first_index;
            s_in = second_index;
            key_in = item_key;
            depth_in = '0;
            err_in = 1'b0;
            tail_in = '0;
         end
         lhc_pkg::ST_START: begin
            a_in = f_ff;
            b_in = s_ff;
            case (cmd_ff)
               lhc_pkg::CMD_INSERT: begin
                  err_in = f_ff > MAX_IDX || s_ff > MAX_IDX;
                  node_re = 1'b1;
                  node_raddr = f_ff;
               end
               lhc_pkg::CMD_MELD: begin
                  err_in = f_ff > MAX_IDX || s_ff > MAX_IDX;
               end
               lhc_pkg::CMD_DELMIN: begin
                  err_in = s_ff > MAX_IDX;
                  node_re = 1'b1;
                  node_raddr = s_ff;
               end
               default: err_in = 1'b1;
            endcase
            rd_idx_in = node_raddr;
         end
         lhc_pkg::ST_CHECK: begin
            ks_in = rd_key_raw;
            if (cmd_ff == lhc_pkg::CMD_INSERT) begin
               err_in = rd_left != '0 || rd_right != '0 || rd_rank != lhc_pkg::RANK_ONE;
            end else begin
               a_in = rd_left;
               b_in = rd_right;
            end
         end
         lhc_pkg::ST_WALK: begin
            node_re = 1'b1;
            if (spine_end) begin
               node_raddr = (a_ff != '0) ? a_ff : b_ff;
               tail_in = node_raddr;
            end else begin
               node_raddr = a_ff;
            end
            rd_idx_in = node_raddr;
         end
         lhc_pkg::ST_WALK_A: begin
            ka_in = rd_key;
            ra_in = rd_right;
            node_re = 1'b1;
            node_raddr = b_ff;
            rd_idx_in = b_ff;
         end
         lhc_pkg::ST_WALK_B: begin
            if (depth_ff == DEP_MAX) begin
               err_in = 1'b1;
            end else begin
               stk_we = 1'b1;
               stk_wdata = greater ? b_ff : a_ff;
               depth_in = depth_ff + DEP_W'(1);
               if (greater) begin
                  a_in = rd_right;
                  b_in = a_ff;
               end else begin
                  a_in = ra_ff;
               end
            end
         end
         lhc_pkg::ST_TAIL: trank_in = rd_rank;
         lhc_pkg::ST_POP: begin
            if (depth_ff != '0) begin
               stk_re = 1'b1;
               depth_in = depth_ff - DEP_W'(1);
            end else if (cmd_ff == lhc_pkg::CMD_INSERT) begin
               node_re = 1'b1;
               node_raddr = f_ff;
               rd_idx_in = f_ff;
            end
         end
         lhc_pkg::ST_POP_X: begin
            x_in = stk_rdata;
            node_re = 1'b1;
            node_raddr = stk_rdata;
            rd_idx_in = stk_rdata;
         end
         lhc_pkg::ST_POP_L: begin
            xk_in = rd_key;
            xl_in = rd_left;
            node_re = 1'b1;
            node_raddr = rd_left;
            rd_idx_in = rd_left;
         end
         lhc_pkg::ST_POP_W: begin
            node_we = 1'b1;
            node_waddr = x_ff;
            node_wdata = swap ? {xk_ff, tail_ff, xl_ff, new_rank}
                              : {xk_ff, xl_ff, tail_ff, new_rank};
            tail_in = x_ff;
            trank_in = new_rank;
         end
         lhc_pkg::ST_FIN_WR: begin
            node_we = 1'b1;
            node_waddr = f_ff;
            node_wdata = {key_ff, rd_left, rd_right, rd_rank};
         end
         lhc_pkg::ST_DEL_WR: begin
            node_we = 1'b1;
            node_waddr = s_ff;
            node_wdata = {ks_ff, IDX_W'(0), IDX_W'(0), lhc_pkg::RANK_ONE};
         end
         lhc_pkg::ST_DONE: stat.done = rsp_free;
         default: ;
      endcase
   end

   assign result_root = err_ff ? '0 : tail_ff;
   assign removed_item = (!err_ff && cmd_ff == lhc_pkg::CMD_DELMIN) ? s_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhc_pkg::ST_CLEAR;
         clr_ff <= '0;
         depth_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         depth_ff <= depth_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      f_ff <= f_in;
      s_ff <= s_in;
      key_ff <= key_in;
      ks_ff <= ks_in;
      ka_ff <= ka_in;
      a_ff <= a_in;
      b_ff <= b_in;
      ra_ff <= ra_in;
      tail_ff <= tail_in;
      x_ff <= x_in;
      xl_ff <= xl_in;
      xk_ff <= xk_in;
      trank_ff <= trank_in;
      rd_idx_ff <= rd_idx_in;
   end

   a_entry_zero: assert property (@(posedge clock) disable iff (reset)
      node_we && state_ff != lhc_pkg::ST_CLEAR |-> node_waddr != '0)
      else $error("node entry zero written outside the clearing pass");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEP_MAX)
      else $error("spine stack depth out of range");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> rsp_free && state_in == lhc_pkg::ST_IDLE)
      else $error("result issued while the output register is busy");

   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      err_ff && state_ff == lhc_pkg::ST_DONE |-> !node_we)
      else $error("node memory written after an error");

endmodule

// ----- src/leftist_heap_collection.sv -----
// ----------------------------------------------------------------------------
// leftist_heap_collection
// Collection of leftist min-heaps kept in a node memory, with insert, meld
// and delete-minimum commands.
//
//   channel | ports      | tdata (low bit up)                | tuser
//   input   | req_*      | first_index, second_index, key    | command
//   result  | rsp_*      | result_root, removed_item         | status
//
// After reset the node memory is cleared, entries 0 to MAX_ITEMS; no item is
// accepted during that time. Each node on the merged right spine is walked (ST_WALK,
// ST_WALK_A, ST_WALK_B) and then unwound (ST_POP, ST_POP_X, ST_POP_L, ST_POP_W); an
// insert or a delete-minimum also reads its item first and rewrites it last. One item
// is worked on at a time. A finished result waits in an output register while the
// next item is accepted; a stalled result stalls only the end of the following item.
// ----------------------------------------------------------------------------
module leftist_heap_collection #(
   parameter int MAX_ITEMS   = 1024,
   parameter int SPINE_DEPTH = 24,
   localparam int IDX_W = $clog2(MAX_ITEMS + 1),
   localparam int REQ_W = ((2 * IDX_W + lhc_pkg::KEY_W + 7) / 8) * 8,
   localparam int RSP_W = ((2 * IDX_W + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,  // first_index, second_index, item_key
   input  logic [lhc_pkg::CMD_W-1:0] req_tuser, // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata,  // result_root, removed_item
   output logic                     rsp_tuser   // status
);

   localparam int SP_W  = $clog2(SPINE_DEPTH);
   localparam int REC_W = lhc_pkg::KEY_W + 2 * IDX_W + lhc_pkg::RANK_W;

   logic idle, rsp_free;
   lhc_pkg::ctrl_stat_type stat;
   logic [IDX_W-1:0] result_root, removed_item;
   logic node_we, node_re, stk_we, stk_re;
   logic [IDX_W-1:0] node_waddr, node_raddr, stk_wdata, stk_rdata;
   logic [REC_W-1:0] node_wdata, node_rdata;
   logic [SP_W-1:0] stk_addr_w, stk_addr_r;

   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] root_ff, removed_ff;
   logic status_ff;

   assign req_tready = idle;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   lhc_ctrl #(
      .MAX_ITEMS(MAX_ITEMS),
      .SPINE_DEPTH(SPINE_DEPTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(req_tvalid),
      .idle(idle),
      .cmd(lhc_pkg::cmd_type'(req_tuser)),
      .first_index(req_tdata[IDX_W-1:0]),
      .second_index(req_tdata[2*IDX_W-1:IDX_W]),
      .item_key(req_tdata[2*IDX_W+lhc_pkg::KEY_W-1:2*IDX_W]),
      .rsp_free(rsp_free),
      .stat(stat),
      .result_root(result_root),
      .removed_item(removed_item),
      .node_we(node_we),
      .node_waddr(node_waddr),
      .node_wdata(node_wdata),
      .node_re(node_re),
      .node_raddr(node_raddr),
      .node_rdata(node_rdata),
      .stk_we(stk_we),
      .stk_addr_w(stk_addr_w),
      .stk_wdata(stk_wdata),
      .stk_re(stk_re),
      .stk_addr_r(stk_addr_r),
      .stk_rdata(stk_rdata)
   );

   lhc_ram #(
      .WIDTH(REC_W),
      .DEPTH(MAX_ITEMS + 1)
   ) u_node_ram (
      .clock(clock),
      .we(node_we),
      .waddr(node_waddr),
      .wdata(node_wdata),
      .re(node_re),
      .raddr(node_raddr),
      .rdata(node_rdata)
   );

   lhc_ram #(
      .WIDTH(IDX_W),
      .DEPTH(SPINE_DEPTH)
   ) u_stack_ram (
      .clock(clock),
      .we(stk_we),
      .waddr(stk_addr_w),
      .wdata(stk_wdata),
      .re(stk_re),
      .raddr(stk_addr_r),
      .rdata(stk_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (stat.done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         root_ff <= result_root;
         removed_ff <= removed_item;
         status_ff <= stat.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_W'({removed_ff, root_ff});
   assign rsp_tuser = status_ff;

endmodule

// ----- dv/lhc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lhc_checker
// Watches both channels of the leftist heap collection, keeps its own copy of
// the node memory, works out the result of every accepted item and compares
// it with the items that come back, field by field and in order.
// ----------------------------------------------------------------------------
module lhc_checker #(
   parameter int MAX_ITEMS   = 1024,
   parameter int SPINE_DEPTH = 24,
   parameter int IDX_W       = 11,
   parameter int REQ_W       = 56,
   parameter int RSP_W       = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,
   input  logic [lhc_pkg::CMD_W-1:0] req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_W-1:0]          rsp_tdata,
   input  logic                      rsp_tuser,
   output int                        fail_count,
   output int                        pending_count,
   output int                        error_count
);

   localparam int KEY_W  = lhc_pkg::KEY_W;
   localparam int RANK_W = lhc_pkg::RANK_W;

   typedef struct packed {
      logic [IDX_W-1:0] root;
      logic [IDX_W-1:0] removed;
      logic             status;
   } heap_result_type;

   logic signed [KEY_W-1:0] key_mem [0:MAX_ITEMS];
   logic [IDX_W-1:0]        left_mem [0:MAX_ITEMS];
   logic [IDX_W-1:0]        right_mem [0:MAX_ITEMS];
   logic [RANK_W-1:0]       rank_mem [0:MAX_ITEMS];
   heap_result_type         expected_results [$];

   function automatic bit meld_walk(input int a_in, input int b_in, output int root);
      int a, b, t, depth, tail, x;
      int spine [SPINE_DEPTH];
      logic [RANK_W:0] r;
      a = a_in;
      b = b_in;
      depth = 0;
      while (a != 0 && b != 0 && a != b) begin
         if (key_mem[a] > key_mem[b]) begin
            t = a; a = b; b = t;
         end
         if (depth >= SPINE_DEPTH) return 1'b1;
         spine[depth] = a;
         depth++;
         a = right_mem[a];
      end
      tail = (a != 0) ? a : b;
      while (depth > 0) begin
         depth--;
         x = spine[depth];
         right_mem[x] = IDX_W'(tail);
         if (rank_mem[left_mem[x]] < rank_mem[right_mem[x]]) begin
            t = left_mem[x];
            left_mem[x] = right_mem[x];
            right_mem[x] = IDX_W'(t);
         end
         r = {1'b0, rank_mem[right_mem[x]]} + 1'b1;
         rank_mem[x] = (r > lhc_pkg::RANK_MAX) ? lhc_pkg::RANK_MAX : r[RANK_W-1:0];
         tail = x;
      end
      root = tail;
      return 1'b0;
   endfunction

   function automatic heap_result_type apply_command(input lhc_pkg::cmd_type cmd,
                                                     input int f, input int s,
                                                     input logic signed [KEY_W-1:0] key);
      heap_result_type res;
      logic signed [KEY_W-1:0] old_key;
      int root;
      res = '0;
      root = 0;
      case (cmd)
         lhc_pkg::CMD_INSERT: begin
            if (f > MAX_ITEMS || s > MAX_ITEMS || left_mem[f] != 0 || right_mem[f] != 0
                || rank_mem[f] != lhc_pkg::RANK_ONE) begin
               res.status = 1'b1;
            end else begin
               old_key = key_mem[f];
               key_mem[f] = key;
               if (meld_walk(f, s, root)) begin
                  key_mem[f] = old_key;
                  res.status = 1'b1;
               end
            end
         end
         lhc_pkg::CMD_MELD: begin
            if (f > MAX_ITEMS || s > MAX_ITEMS || meld_walk(f, s, root)) res.status = 1'b1;
         end
         lhc_pkg::CMD_DELMIN: begin
            if (s > MAX_ITEMS) begin
               res.status = 1'b1;
            end else if (s != 0) begin
               if (meld_walk(left_mem[s], right_mem[s], root)) begin
                  res.status = 1'b1;
               end else begin
                  left_mem[s] = '0;
                  right_mem[s] = '0;
                  rank_mem[s] = lhc_pkg::RANK_ONE;
                  res.removed = IDX_W'(s);
               end
            end
         end
         default: res.status = 1'b1;
      endcase
      if (!res.status) res.root = IDX_W'(root);
      else res.removed = '0;
      return res;
   endfunction

   always @(posedge clock) begin
      heap_result_type want;
      if (reset) begin
         for (int i = 0; i <= MAX_ITEMS; i++) begin
            key_mem[i] = '0;
            left_mem[i] = '0;
            right_mem[i] = '0;
            rank_mem[i] = (i == 0) ? '0 : lhc_pkg::RANK_ONE;
         end
         expected_results.delete();
         fail_count <= 0;
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result item with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== want.root) begin
                  $error("result_root: expected %0d, got %0d", want.root,
                         rsp_tdata[IDX_W-1:0]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tdata[2*IDX_W-1:IDX_W] !== want.removed) begin
                  $error("removed_item: expected %0d, got %0d", want.removed,
                         rsp_tdata[2*IDX_W-1:IDX_W]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_command(lhc_pkg::cmd_type'(req_tuser), req_tdata[IDX_W-1:0],
                                 req_tdata[2*IDX_W-1:IDX_W],
                                 req_tdata[2*IDX_W+KEY_W-1:2*IDX_W]);
            if (want.status) error_count <= error_count + 1;
            expected_results.push_back(want);
         end
         pending_count <= expected_results.size();
      end
   end
endmodule

// ----- dv/tb_leftist_heap_collection.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_leftist_heap_collection
// Drives insert, meld and delete-minimum items into the heap collection, with
// random idle cycles on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_leftist_heap_collection;

   localparam int MAX_ITEMS   = 1024;
   localparam int SPINE_DEPTH = 24;
   localparam int KEY_W       = lhc_pkg::KEY_W;
   localparam int IDX_W       = $clog2(MAX_ITEMS + 1);
   localparam int REQ_W       = ((2 * IDX_W + KEY_W + 7) / 8) * 8;
   localparam int RSP_W       = ((2 * IDX_W + 7) / 8) * 8;
   localparam int STALL_LIMIT = 20000;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata;
   logic [lhc_pkg::CMD_W-1:0] req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_W-1:0]          rsp_tdata;
   logic                      rsp_tuser;
   int                        fail_count;
   int                        pending_count;
   int                        error_count;
   int                        idle_cycles;
   int                        items_sent;
   int                        results_seen;
   int                        last_root;
   bit                        steady;
   int                        heap_roots [$];
   int                        free_items [$];

   leftist_heap_collection #(.MAX_ITEMS(MAX_ITEMS), .SPINE_DEPTH(SPINE_DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   lhc_checker #(.MAX_ITEMS(MAX_ITEMS), .SPINE_DEPTH(SPINE_DEPTH), .IDX_W(IDX_W),
                 .REQ_W(REQ_W), .RSP_W(RSP_W)) i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending_count), .error_count(error_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if (reset) begin
         results_seen <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         last_root <= rsp_tdata[IDX_W-1:0];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input lhc_pkg::cmd_type cmd, input int f, input int s,
                            input logic [KEY_W-1:0] key);
      logic [REQ_W-1:0] data;
      data = '0;
      data[IDX_W-1:0] = IDX_W'(f);
      data[2*IDX_W-1:IDX_W] = IDX_W'(s);
      data[2*IDX_W+KEY_W-1:2*IDX_W] = key;
      while (!steady && $urandom_range(99) < 11) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      items_sent++;
   endtask

   // Wait until every item sent so far has its result back.
   task automatic wait_result(output int root);
      while (results_seen != items_sent) @(posedge clock);
      root = last_root;
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // Pick a random heap root and remove it from the list of known roots.
   function automatic int take_root();
      int k;
      int r;
      if (heap_roots.size() == 0) return 0;
      k = $urandom_range(heap_roots.size() - 1);
      r = heap_roots[k];
      heap_roots.delete(k);
      return r;
   endfunction

   // Roots are tracked from the expected behavior of well-formed commands.
   task automatic heap_insert(input int item, input logic [KEY_W-1:0] key);
      int r;
      int s;
      s = take_root();
      send_item(lhc_pkg::CMD_INSERT, item, s, key);
      // The new root is the smaller key of the two; the next result tells it.
      wait_result(r);
      if (r != 0) heap_roots.push_back(r);
      else if (s != 0) heap_roots.push_back(s);
   endtask

   initial begin
      int f;
      int s;
      int r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lhc_pkg::CMD_INSERT;
      steady = 1'b0;
      items_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, every command and the error cases.
      send_item(lhc_pkg::CMD_INSERT, 1, 0, 32'h8000_0000);
      send_item(lhc_pkg::CMD_INSERT, MAX_ITEMS, 1, 32'h7FFF_FFFF);
      send_item(lhc_pkg::CMD_INSERT, 2, 1, 32'h0000_0005);
      send_item(lhc_pkg::CMD_INSERT, 1, 0, 32'h0);
      send_item(lhc_pkg::CMD_INSERT, 0, 0, 32'h0);
      send_item(lhc_pkg::CMD_INSERT, MAX_ITEMS + 1, 0, 32'h0);
      send_item(lhc_pkg::CMD_INSERT, 3, 2047, 32'h0);
      send_item(lhc_pkg::CMD_INSERT, 2047, 0, 32'hFFFF_FFFF);
      send_item(lhc_pkg::CMD_INSERT, 3, 3, 32'hAAAA_AAAA);
      send_item(lhc_pkg::CMD_MELD, 1, 1, 32'h0);
      send_item(lhc_pkg::CMD_MELD, 0, 3, 32'h0);
      send_item(lhc_pkg::CMD_MELD, 1, 3, 32'h0);
      send_item(lhc_pkg::CMD_MELD, 2047, 1, 32'h0);
      send_item(lhc_pkg::CMD_MELD, 1, 1536, 32'h0);
      send_item(lhc_pkg::CMD_DELMIN, 0, 0, 32'h0);
      send_item(lhc_pkg::CMD_DELMIN, 0, 2047, 32'h0);
      send_item(lhc_pkg::CMD_DELMIN, 0, 1, 32'h0);
      send_item(lhc_pkg::CMD_UNUSED, 5, 5, 32'h5555_5555);
      send_item(lhc_pkg::CMD_MELD, 2, 4, 32'h0);
      send_item(lhc_pkg::CMD_DELMIN, 0, 2, 32'h0);
      wait_result(r);

      // Random part: mostly well-formed commands on a growing set of heaps.
      for (int i = 1; i <= MAX_ITEMS; i++) free_items.push_back(i);
      for (int i = 1; i <= MAX_ITEMS; i++) begin
         r = $urandom_range(free_items.size() - 1);
         f = free_items[r];
         free_items[r] = free_items[i - 1];
         free_items[i - 1] = f;
      end
      // Items 1..4 and the last item already hold heap content; leave them to
      // the noise below.
      for (int i = free_items.size() - 1; i >= 0; i--)
         if (free_items[i] <= 4 || free_items[i] == MAX_ITEMS) free_items.delete(i);

      for (int n = 0; n < 500; n++) begin
         steady = (n >= 200 && n < 280);
         r = $urandom_range(99);
         if (r < 45 && free_items.size() != 0) begin
            heap_insert(free_items.pop_front(), random_key());
         end else if (r < 70 && heap_roots.size() >= 2) begin
            f = take_root();
            s = take_root();
            send_item(lhc_pkg::CMD_MELD, f, s, $urandom);
            wait_result(r);
            heap_roots.push_back(r);
         end else if (r < 90 && heap_roots.size() != 0) begin
            s = take_root();
            send_item(lhc_pkg::CMD_DELMIN, $urandom, s, $urandom);
            wait_result(r);
            if (r != 0) heap_roots.push_back(r);
            free_items.push_back(s);
         end else begin
            // Noise: arbitrary operands, which may be misuse; heaps stay valid
            // or the result is an error that changes nothing only for roots.
            f = $urandom_range(2047);
            s = (heap_roots.size() != 0 && $urandom_range(1)) ? heap_roots[0] : 0;
            case ($urandom_range(3))
               0: send_item(lhc_pkg::CMD_UNUSED, f, s, $urandom);
               1: send_item(lhc_pkg::CMD_INSERT, MAX_ITEMS + 1 + $urandom_range(1022), s,
                            $urandom);
               2: send_item(lhc_pkg::CMD_MELD, s, s, $urandom);
               default: send_item(lhc_pkg::CMD_DELMIN, f,
                                  MAX_ITEMS + 1 + $urandom_range(1022), $urandom);
            endcase
            wait_result(r);
         end
      end
      steady = 1'b0;

      wait_result(r);
      repeat (200) @(posedge clock);
      $display("Sent %0d items of all commands, %0d of them expected to fail.",
               items_sent, error_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
